FILE: rtl/core/mssr_pkg.sv
// Shared constants, codes and lookup functions of the servo slew ramp.
package mssr_pkg;

  localparam int SERVO_COUNT_DEF   = 5;
  localparam int GESTURE_COUNT_DEF = 5;

  // Action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_GESTURE = 3'd1;
  localparam logic [2:0] ACT_BRAKE   = 3'd2;
  localparam logic [2:0] ACT_SET     = 3'd3;
  localparam logic [2:0] ACT_START   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_REST   = 3'd0;
  localparam logic [2:0] REG_EXT    = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_RATE   = 3'd3;

  // Gesture codes
  localparam logic [2:0] GST_PINCH  = 3'd1;
  localparam logic [2:0] GST_TRIPOD = 3'd2;
  localparam logic [2:0] GST_POWER  = 3'd3;
  localparam logic [2:0] GST_EXT    = 3'd4;

  localparam logic [7:0] REST_RESET   = 8'd20;
  localparam logic [7:0] EXT_RESET    = 8'd0;
  localparam logic [9:0] PERIOD_RESET = 10'd20;
  localparam logic [9:0] RATE_RESET   = 10'd180;
  localparam logic [7:0] UNWRITTEN    = 8'd255;

  // Step math: step = floor(rate * dt * 256 / 1000), saturated at 16 bits.
  // rate * dt >= STEP_SAT_PROD always saturates; dt is clamped to 18 bits.
  localparam int          DT_W          = 18;
  localparam int          PROD_W        = 28;
  localparam int          NUM_W         = 23;
  localparam logic [27:0] STEP_SAT_PROD = 28'd256000;
  localparam int          RECIP_SHIFT   = 30;
  localparam logic [23:0] RECIP_125     = 24'((64'd1 << RECIP_SHIFT) / 64'd125);
  localparam logic [6:0]  DIV_125       = 7'd125;

  // Pulse count: floor((45 + a) * 512 / 225), clamped to 102..512
  localparam int PULSE_OFS = 45;
  localparam int PULSE_MUL = 512;
  localparam int PULSE_DEN = 225;
  localparam int PULSE_MIN = 102;
  localparam int PULSE_MAX = 512;

  typedef logic [9:0] pulse_lut_t [256];

  function automatic pulse_lut_t build_pulse_lut();
    pulse_lut_t lut;
    int         c;
    int         i;
    for (i = 0; i < 256; i++) begin
      c = ((PULSE_OFS + i) * PULSE_MUL) / PULSE_DEN;
      if (c < PULSE_MIN) c = PULSE_MIN;
      if (c > PULSE_MAX) c = PULSE_MAX;
      lut[i] = 10'(c);
    end
    return lut;
  endfunction

  localparam pulse_lut_t PULSE_LUT = build_pulse_lut();

  // Round Q8.8 half up to whole degrees, saturate at 255
  function automatic logic [7:0] round_q8(input logic [15:0] q);
    logic [16:0] s;
    s = {1'b0, q} + 17'd128;
    return s[16] ? 8'd255 : s[15:8];
  endfunction

  // Target angle of one channel for a gesture; unknown ids mean rest
  function automatic logic [7:0] gesture_angle(input logic [2:0] g, input logic [2:0] ch,
                                               input logic [7:0] rest, input logic [7:0] ext);
    logic [7:0] a;
    a = rest;
    case (g)
      GST_PINCH: begin
        if (ch == 3'd0) a = 8'd180;
        else if (ch == 3'd1) a = 8'd120;
      end
      GST_TRIPOD: begin
        if (ch == 3'd0) a = 8'd180;
        else if (ch == 3'd1) a = 8'd150;
        else if (ch == 3'd2) a = 8'd120;
      end
      GST_POWER: begin
        case (ch)
          3'd0: a = 8'd180;
          3'd1: a = 8'd170;
          3'd2: a = 8'd170;
          3'd3: a = 8'd150;
          3'd4: a = 8'd140;
          default: a = rest;
        endcase
      end
      GST_EXT: begin
        if (ch < 3'd5) a = ext;
      end
      default: a = rest;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/multi_servo_slew_ramp.sv
// Slew-rate-limited ramp controller for a bank of servo channels.
//
// Each accepted item (start, gesture, brake, set angle or tick) produces one status
// transfer per channel, in channel order, the final one flagged by out_last. The
// channels are visited by one shared update unit, each in an update phase and then
// a status phase, and the status phase waits while out_stall holds a full output
// register. Every tick first passes an elapsed time check, and a tick that moves the
// ramp then passes the rate product, reciprocal divide by 1000 and correction steps
// to form the step. Start, gesture, brake, set angle and unknown codes go straight
// to the channel sweep. in_stall stays high until the last status is loaded into the
// output register.
module multi_servo_slew_ramp #(
  parameter int SERVO_COUNT   = mssr_pkg::SERVO_COUNT_DEF,
  parameter int GESTURE_COUNT = mssr_pkg::GESTURE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [2:0]  in_gesture_id,
  input  logic [2:0]  in_chan_sel,
  input  logic [7:0]  in_angle,
  // status
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel,
  output logic [7:0]  out_angle_now,
  output logic        out_moving,
  output logic        out_write_pulse,
  output logic [9:0]  out_pulse_counts,
  output logic        out_last
);

  localparam int         CH_W    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(SERVO_COUNT - 1);
  localparam logic [3:0] SERVO_LIM   = 4'(SERVO_COUNT);
  localparam logic [3:0] GESTURE_LIM = 4'(GESTURE_COUNT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DT    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RECIP = 3'd3;
  localparam logic [2:0] ST_CORR  = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;

  logic [2:0]  state_r;
  logic        phase_r;
  logic [CH_W-1:0] ch_r;

  logic [7:0]  rest_r, ext_r;
  logic [9:0]  period_r, rate_r;

  logic [15:0] cmd_r  [SERVO_COUNT];
  logic [7:0]  tgt_r  [SERVO_COUNT];
  logic [7:0]  lw_r   [SERVO_COUNT];
  logic [31:0] last_ramp_r;
  logic        started_r;

  logic [2:0]  action_r, gid_r, sid_r;
  logic [31:0] now_r;
  logic [7:0]  ang_r;
  logic        move_r;
  logic        wrote_r;

  logic [mssr_pkg::DT_W-1:0]   dt_r;
  logic [mssr_pkg::PROD_W-1:0] prod_r;
  logic [mssr_pkg::NUM_W-1:0]  num_r;
  logic [15:0] q0_r;
  logic        sat_r;
  logic [15:0] step_r;

  logic        out_valid_r, out_last_r, out_moving_r, out_write_r;
  logic [2:0]  out_channel_r;
  logic [7:0]  out_angle_r;
  logic [9:0]  out_pulse_r;

  logic        in_xfer, out_free, out_load;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_SWEEP) && phase_r && out_free;
  assign cfg_ready = 1'b1;

  // Step pipeline front end
  logic [31:0] dt;
  logic        ramp_go;
  logic [46:0] recip_prod;
  logic [mssr_pkg::NUM_W-1:0] num;
  logic [mssr_pkg::NUM_W-1:0] rem;
  assign dt      = now_r - last_ramp_r;
  assign ramp_go = started_r && (dt >= {22'd0, period_r});
  assign num     = {prod_r[17:0], 5'd0};
  assign recip_prod = 47'(num) * 47'(mssr_pkg::RECIP_125);
  assign rem     = num_r - mssr_pkg::NUM_W'(q0_r) * mssr_pkg::NUM_W'(mssr_pkg::DIV_125);

  // Shared channel update unit
  logic [15:0] cq, tq16, cq_nxt, diff_up, diff_dn;
  logic [7:0]  tgt_nxt, lw_nxt, rnd;
  logic        wrote_nxt, sid_hit;
  logic [2:0]  ch3, gid_eff;

  assign ch3     = 3'(ch_r);
  assign cq      = cmd_r[ch_r];
  assign tq16    = {tgt_r[ch_r], 8'd0};
  assign diff_up = tq16 - cq;
  assign diff_dn = cq - tq16;
  assign sid_hit = ({1'b0, sid_r} < SERVO_LIM) && (sid_r == ch3);
  assign gid_eff = ({1'b0, gid_r} < GESTURE_LIM) ? gid_r : 3'd0;

  always_comb begin
    cq_nxt    = cq;
    tgt_nxt   = tgt_r[ch_r];
    lw_nxt    = lw_r[ch_r];
    wrote_nxt = 1'b0;
    rnd       = 8'd0;
    case (action_r)
      mssr_pkg::ACT_START: begin
        cq_nxt    = {rest_r, 8'd0};
        tgt_nxt   = rest_r;
        lw_nxt    = rest_r;
        wrote_nxt = 1'b1;
      end
      mssr_pkg::ACT_GESTURE: begin
        tgt_nxt = mssr_pkg::gesture_angle(gid_eff, ch3, rest_r, ext_r);
      end
      mssr_pkg::ACT_BRAKE: begin
        if (sid_hit) tgt_nxt = mssr_pkg::round_q8(cq);
      end
      mssr_pkg::ACT_SET: begin
        if (sid_hit) begin
          cq_nxt    = {ang_r, 8'd0};
          tgt_nxt   = ang_r;
          lw_nxt    = ang_r;
          wrote_nxt = 1'b1;
        end
      end
      mssr_pkg::ACT_TICK: begin
        if (move_r) begin
          if (tq16 >= cq) cq_nxt = (diff_up <= step_r) ? tq16 : cq + step_r;
          else            cq_nxt = (diff_dn <= step_r) ? tq16 : cq - step_r;
          rnd = mssr_pkg::round_q8(cq_nxt);
          if (rnd != lw_r[ch_r]) begin
            lw_nxt    = rnd;
            wrote_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Status of the current channel from its stored state
  logic [7:0]  st_angle;
  logic [15:0] st_diff;
  assign st_angle = mssr_pkg::round_q8(cq);
  assign st_diff  = (tq16 >= cq) ? diff_up : diff_dn;

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      ch_r        <= '0;
      rest_r      <= mssr_pkg::REST_RESET;
      ext_r       <= mssr_pkg::EXT_RESET;
      period_r    <= mssr_pkg::PERIOD_RESET;
      rate_r      <= mssr_pkg::RATE_RESET;
      last_ramp_r <= '0;
      started_r   <= 1'b0;
      move_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        cmd_r[i] <= {mssr_pkg::REST_RESET, 8'd0};
        tgt_r[i] <= mssr_pkg::REST_RESET;
        lw_r[i]  <= mssr_pkg::UNWRITTEN;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mssr_pkg::REG_REST:   rest_r   <= cfg_data[7:0];
          mssr_pkg::REG_EXT:    ext_r    <= cfg_data[7:0];
          mssr_pkg::REG_PERIOD: period_r <= cfg_data;
          mssr_pkg::REG_RATE:   rate_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            move_r  <= 1'b0;
            ch_r    <= '0;
            phase_r <= 1'b0;
            if (in_action == mssr_pkg::ACT_START) begin
              started_r   <= 1'b1;
              last_ramp_r <= in_now_ms;
            end
            state_r <= (in_action == mssr_pkg::ACT_TICK) ? ST_DT : ST_SWEEP;
          end
        end
        ST_DT: begin
          if (ramp_go) begin
            last_ramp_r <= now_r;
            move_r      <= 1'b1;
            state_r     <= ST_MUL;
          end else begin
            state_r <= ST_SWEEP;
          end
        end
        ST_MUL:   state_r <= ST_RECIP;
        ST_RECIP: state_r <= ST_CORR;
        ST_CORR:  state_r <= ST_SWEEP;
        ST_SWEEP: begin
          if (!phase_r) begin
            cmd_r[ch_r] <= cq_nxt;
            tgt_r[ch_r] <= tgt_nxt;
            lw_r[ch_r]  <= lw_nxt;
            phase_r     <= 1'b1;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            phase_r     <= 1'b0;
            if (ch_r == CH_LAST) state_r <= ST_IDLE;
            else ch_r <= ch_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_r <= in_action;
      now_r    <= in_now_ms;
      gid_r    <= in_gesture_id;
      sid_r    <= in_chan_sel;
      ang_r    <= in_angle;
    end
    if (state_r == ST_DT) begin
      dt_r <= (|dt[31:mssr_pkg::DT_W]) ? '1 : dt[mssr_pkg::DT_W-1:0];
    end
    if (state_r == ST_MUL) begin
      prod_r <= mssr_pkg::PROD_W'(rate_r) * mssr_pkg::PROD_W'(dt_r);
    end
    if (state_r == ST_RECIP) begin
      sat_r <= (prod_r >= mssr_pkg::STEP_SAT_PROD);
      num_r <= num;
      q0_r  <= recip_prod[mssr_pkg::RECIP_SHIFT +: 16];
    end
    if (state_r == ST_CORR) begin
      if (sat_r) step_r <= 16'hFFFF;
      else if (rem >= mssr_pkg::NUM_W'(mssr_pkg::DIV_125)) step_r <= q0_r + 16'd1;
      else step_r <= q0_r;
    end
    if (state_r == ST_SWEEP && !phase_r) wrote_r <= wrote_nxt;
    if (out_load) begin
      out_channel_r <= ch3;
      out_angle_r   <= st_angle;
      out_moving_r  <= (st_diff > 16'd128);
      out_write_r   <= wrote_r;
      out_pulse_r   <= mssr_pkg::PULSE_LUT[st_angle];
      out_last_r    <= (ch_r == CH_LAST);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_angle_now    = out_angle_r;
  assign out_moving       = out_moving_r;
  assign out_write_pulse  = out_write_r;
  assign out_pulse_counts = out_pulse_r;
  assign out_last         = out_last_r;

  // Checks
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("item transfer did not start processing");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CH_LAST)
    else $error("channel counter out of range");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_action == mssr_pkg::ACT_START) |=> started_r)
    else $error("start did not arm the ramp");

  a_move_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    move_r |-> started_r)
    else $error("ramp moved before start");

endmodule

FILE: verif/multi_servo_slew_ramp_tb.sv
// Self-checking testbench for the servo slew ramp: random handshakes, predicted status.
module multi_servo_slew_ramp_tb;
  import mssr_pkg::*;

  localparam int          CHAN_COUNT   = SERVO_COUNT_DEF;
  localparam int          IDLE_PCT     = 37;
  localparam int          CALM_FROM    = 2500;
  localparam int          CALM_TO      = 4500;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          QUIET_LIMIT  = 3000;
  localparam int          RUN_ITEMS    = 85;
  localparam logic [2:0]  ACT_BOGUS_LO = ACT_START + 3'd1;
  localparam logic [2:0]  ACT_BOGUS_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [2:0]  gesture_id;
    logic [2:0]  chan_sel;
    logic [7:0]  angle;
  } servo_cmd_t;

  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] angle_now;
    logic       moving;
    logic       write_pulse;
    logic [9:0] pulse_counts;
    logic       last;
  } servo_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_REST;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = ACT_TICK;
  logic [31:0] in_now_ms = '0;
  logic [2:0]  in_gesture_id = '0;
  logic [2:0]  in_chan_sel = '0;
  logic [7:0]  in_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_channel;
  logic [7:0]  out_angle_now;
  logic        out_moving;
  logic        out_write_pulse;
  logic [9:0]  out_pulse_counts;
  logic        out_last;

  multi_servo_slew_ramp u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_now_ms(in_now_ms),
    .in_gesture_id(in_gesture_id), .in_chan_sel(in_chan_sel), .in_angle(in_angle),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .out_angle_now(out_angle_now), .out_moving(out_moving), .out_write_pulse(out_write_pulse),
    .out_pulse_counts(out_pulse_counts), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // Predicted servo state and register copy
  logic [15:0] pos_q8 [CHAN_COUNT];
  logic [7:0]  aim_deg [CHAN_COUNT];
  logic [7:0]  sent_deg [CHAN_COUNT];
  logic [31:0] ramp_stamp;
  logic        running;
  logic [7:0]  rest_deg;
  logic [7:0]  ext_deg;
  logic [9:0]  period_ms;
  logic [9:0]  rate_dps;

  servo_cmd_t    cmd_q[$];
  servo_status_t status_q[$];
  servo_cmd_t    cur_cmd;
  int            cmds_queued = 0;
  int            cmds_taken = 0;
  int            results_seen = 0;
  int            bad_count = 0;
  int            cyc = 0;
  int            hold_left = 0;
  int            next_hold_at = 300;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit take_break();
    return (cyc < CALM_FROM || cyc >= CALM_TO) && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [7:0] q8_to_deg(input logic [15:0] q);
    logic [16:0] r;
    r = (17'(q) + 17'd128) >> 8;
    return (r > 17'd255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [9:0] counts_for(input logic [7:0] a);
    logic [63:0] c;
    c = (64'd90000 + 64'd2000 * 64'(a)) * 64'd4096 / 64'd3600000;
    if (c < 64'd102) c = 64'd102;
    if (c > 64'd512) c = 64'd512;
    return c[9:0];
  endfunction

  function automatic logic [7:0] gesture_aim(input logic [2:0] g, input int ch);
    logic [7:0] a;
    a = rest_deg;
    case (g)
      GST_PINCH:  if (ch == 0) a = 8'd180; else if (ch == 1) a = 8'd120;
      GST_TRIPOD: if (ch == 0) a = 8'd180; else if (ch == 1) a = 8'd150;
                  else if (ch == 2) a = 8'd120;
      GST_POWER: begin
        case (ch)
          0: a = 8'd180;
          1: a = 8'd170;
          2: a = 8'd170;
          3: a = 8'd150;
          default: a = 8'd140;
        endcase
      end
      GST_EXT: a = ext_deg;
      default: a = rest_deg;
    endcase
    return a;
  endfunction

  task automatic reset_servos();
    rest_deg = REST_RESET;
    ext_deg = EXT_RESET;
    period_ms = PERIOD_RESET;
    rate_dps = RATE_RESET;
    for (int i = 0; i < CHAN_COUNT; i++) begin
      pos_q8[i] = {rest_deg, 8'h00};
      aim_deg[i] = rest_deg;
      sent_deg[i] = UNWRITTEN;
    end
    ramp_stamp = '0;
    running = 1'b0;
  endtask

  // Apply one command to the predicted state and queue the status of every channel
  task automatic advance_servos(input servo_cmd_t c);
    logic          wrote [CHAN_COUNT];
    logic [31:0]   dt;
    logic [63:0]   step;
    logic [31:0]   tq;
    logic [31:0]   cq;
    logic [31:0]   diff;
    logic [7:0]    deg;
    servo_status_t s;
    for (int i = 0; i < CHAN_COUNT; i++) wrote[i] = 1'b0;
    case (c.action)
      ACT_START: begin
        running = 1'b1;
        for (int i = 0; i < CHAN_COUNT; i++) begin
          pos_q8[i] = {rest_deg, 8'h00};
          aim_deg[i] = rest_deg;
          sent_deg[i] = rest_deg;
          wrote[i] = 1'b1;
        end
        ramp_stamp = c.now_ms;
      end
      ACT_GESTURE: begin
        for (int i = 0; i < CHAN_COUNT; i++) aim_deg[i] = gesture_aim(c.gesture_id, i);
      end
      ACT_BRAKE: begin
        if (c.chan_sel < CHAN_COUNT) aim_deg[c.chan_sel] = q8_to_deg(pos_q8[c.chan_sel]);
      end
      ACT_SET: begin
        if (c.chan_sel < CHAN_COUNT) begin
          pos_q8[c.chan_sel] = {c.angle, 8'h00};
          aim_deg[c.chan_sel] = c.angle;
          sent_deg[c.chan_sel] = c.angle;
          wrote[c.chan_sel] = 1'b1;
        end
      end
      ACT_TICK: begin
        dt = c.now_ms - ramp_stamp;
        if (running && dt >= 32'(period_ms)) begin
          step = 64'(rate_dps) * 64'(dt) * 64'd256 / 64'd1000;
          if (step > 64'hFFFF) step = 64'hFFFF;
          ramp_stamp = c.now_ms;
          for (int i = 0; i < CHAN_COUNT; i++) begin
            tq = {16'h0, aim_deg[i], 8'h00};
            cq = 32'(pos_q8[i]);
            if (tq >= cq) cq = (tq - cq <= step[31:0]) ? tq : cq + step[31:0];
            else cq = (cq - tq <= step[31:0]) ? tq : cq - step[31:0];
            pos_q8[i] = cq[15:0];
            deg = q8_to_deg(cq[15:0]);
            if (deg != sent_deg[i]) begin
              sent_deg[i] = deg;
              wrote[i] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CHAN_COUNT; i++) begin
      tq = {16'h0, aim_deg[i], 8'h00};
      cq = 32'(pos_q8[i]);
      diff = (tq >= cq) ? tq - cq : cq - tq;
      s.channel = 3'(i);
      s.angle_now = q8_to_deg(pos_q8[i]);
      s.moving = diff > 32'd128;
      s.write_pulse = wrote[i];
      s.pulse_counts = counts_for(s.angle_now);
      s.last = (i == CHAN_COUNT - 1);
      status_q.push_back(s);
    end
  endtask

  // Driver: hold the payload while stalled, advance on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_servos(cur_cmd);
        cmds_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && !take_break()) begin
          cur_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_cmd.action;
          in_now_ms <= cur_cmd.now_ms;
          in_gesture_id <= cur_cmd.gesture_id;
          in_chan_sel <= cur_cmd.chan_sel;
          in_angle <= cur_cmd.angle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each status transfer against the oldest prediction
  always @(posedge clk) begin
    servo_status_t got;
    servo_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_channel, out_angle_now, out_moving, out_write_pulse, out_pulse_counts,
                out_last};
        results_seen++;
        if (status_q.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected status: ch=%0d ang=%0d mov=%0b wr=%0b cnt=%0d last=%0b",
                     got.channel, got.angle_now, got.moving, got.write_pulse,
                     got.pulse_counts, got.last);
          bad_count++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (bad_count < 10) begin
              $display("status mismatch: exp ch=%0d ang=%0d mov=%0b wr=%0b cnt=%0d last=%0b",
                       want.channel, want.angle_now, want.moving, want.write_pulse,
                       want.pulse_counts, want.last);
              $display("                 got ch=%0d ang=%0d mov=%0b wr=%0b cnt=%0d last=%0b",
                       got.channel, got.angle_now, got.moving, got.write_pulse,
                       got.pulse_counts, got.last);
            end
            bad_count++;
          end
        end
      end
      // Hold off for a long stretch now and then so the block backs up
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 1200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= take_break();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** multi_servo_slew_ramp: FAILED **");
    $finish;
  end

  task automatic queue_cmd(input logic [2:0] act, input logic [31:0] now_ms,
                           input logic [2:0] gid, input logic [2:0] sid, input logic [7:0] ang);
    servo_cmd_t c;
    c = '{act, now_ms, gid, sid, ang};
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_REST:   rest_deg = val[7:0];
      REG_EXT:    ext_deg = val[7:0];
      REG_PERIOD: period_ms = val;
      REG_RATE:   rate_dps = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_queued || status_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_servo();
    return ($urandom_range(99) < 85) ? 3'($urandom_range(CHAN_COUNT - 1))
                                     : 3'($urandom_range(7, CHAN_COUNT));
  endfunction

  // Mostly start-then-ramp sequences with time moving forward; some noise mixed in
  task automatic queue_random_run(input int n);
    logic [31:0] clock_ms;
    logic [31:0] now_ms;
    logic [2:0]  act;
    int          r;
    clock_ms = $urandom();
    queue_cmd(ACT_START, clock_ms, 3'($urandom_range(7)), 3'($urandom_range(7)),
              8'($urandom_range(255)));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(99);
      now_ms = $urandom();
      if (r < 45) begin
        act = ACT_TICK;
        clock_ms += $urandom_range(2 * int'(period_ms) + 4);
        now_ms = clock_ms;
      end else if (r < 50) begin
        act = ACT_TICK;
        clock_ms += $urandom_range(300000);
        now_ms = clock_ms;
      end else if (r < 53) begin
        act = ACT_TICK;
      end else if (r < 68) begin
        act = ACT_GESTURE;
      end else if (r < 77) begin
        act = ACT_BRAKE;
      end else if (r < 90) begin
        act = ACT_SET;
      end else if (r < 95) begin
        act = ACT_START;
        clock_ms += $urandom_range(50);
        now_ms = clock_ms;
      end else begin
        act = 3'($urandom_range(ACT_BOGUS_HI, ACT_BOGUS_LO));
      end
      queue_cmd(act, now_ms, 3'($urandom_range(7)), pick_servo(), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    reset_servos();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: moves before start, ignored codes, every gesture, timing corners
    queue_cmd(ACT_SET, 32'd0, 3'd0, 3'd2, 8'd255);
    queue_cmd(ACT_TICK, 32'd1000, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_BRAKE, 32'd0, 3'd0, 3'd7, 8'd0);
    queue_cmd(ACT_BOGUS_LO, 32'hFFFF_FFFF, 3'd7, 3'd1, 8'd255);
    queue_cmd(ACT_BOGUS_LO + 3'd1, 32'h5555_AAAA, 3'd2, 3'd3, 8'd90);
    queue_cmd(ACT_BOGUS_HI, 32'hAAAA_5555, 3'd5, 3'd0, 8'd1);
    queue_cmd(ACT_START, 32'hFFFF_FFF0, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, 3'd5, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, 3'd6, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, 3'd7, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, GST_PINCH, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, GST_TRIPOD, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, GST_EXT, 3'd0, 8'd0);
    queue_cmd(ACT_GESTURE, 32'd0, GST_POWER, 3'd0, 8'd0);
    queue_cmd(ACT_TICK, 32'hFFFF_FFF5, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_TICK, 32'h0000_0010, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_BRAKE, 32'd0, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_SET, 32'd0, 3'd0, 3'd4, 8'd0);
    queue_cmd(ACT_SET, 32'd0, 3'd0, 3'd5, 8'd77);
    queue_cmd(ACT_TICK, 32'h8000_0010, 3'd0, 3'd0, 8'd0);
    queue_cmd(ACT_SET, 32'd0, 3'd0, 3'd1, 8'd128);
    queue_cmd(ACT_TICK, 32'h8000_0010, 3'd0, 3'd0, 8'd0);
    wait_drained();

    for (int run = 0; run < 4; run++) begin
      case (run)
        0: begin
          write_reg(REG_REST, 10'd0);
          write_reg(REG_EXT, 10'd180);
          write_reg(REG_PERIOD, 10'd1);
          write_reg(REG_RATE, 10'd1000);
        end
        1: begin
          write_reg(REG_REST, 10'd180);
          write_reg(REG_EXT, 10'd0);
          write_reg(REG_PERIOD, 10'd1000);
          write_reg(REG_RATE, 10'd1);
        end
        default: begin
          write_reg(REG_REST, 10'($urandom_range(180)));
          write_reg(REG_EXT, 10'($urandom_range(180)));
          write_reg(REG_PERIOD, 10'($urandom_range(60, 1)));
          write_reg(REG_RATE, 10'($urandom_range(1000, 1)));
        end
      endcase
      queue_random_run(RUN_ITEMS);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (bad_count == 0)
      $display("** multi_servo_slew_ramp: PASSED **");
    else
      $display("** multi_servo_slew_ramp: FAILED **");
    $finish;
  end

endmodule

FILE: multi_servo_slew_ramp.f
rtl/core/mssr_pkg.sv
rtl/core/multi_servo_slew_ramp.sv
verif/multi_servo_slew_ramp_tb.sv
